[sv/assert_macros.svh]
// Assertion macros for the RTL module of the digit display writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ddw_pkg.sv]
// Package with the constants, types and conversion functions of the digit display writer.
package ddw_pkg;

	// Width of the binary input value.
	localparam int ValueWidth = 27;
	// Number of display positions that are written for each value.
	localparam int DigitCount = 8;
	// Number of decimal digits that a value of ValueWidth bits can have.
	localparam int BcdDigits = 9;
	localparam int BcdWidth = 4 * BcdDigits;
	// Double-dabble steps, one per input bit, and the steps done in each stage.
	localparam int DabbleSteps = ValueWidth;
	localparam int StageSteps = 7;
	localparam int LastSteps = DabbleSteps - 3 * StageSteps;
	// Width of the position counter of the output serializer.
	localparam int CountWidth = $clog2(DigitCount);
	localparam int AddrWidth = 4;
	localparam int CodeWidth = 8;

	// Display codes and positions.
	localparam logic [CodeWidth-1:0] BlankCode = 8'h0F;
	localparam logic [CodeWidth-1:0] PointBit = 8'h80;
	localparam logic [AddrWidth-1:0] PointPosition = 4'h3;
	localparam int AlwaysShown = 3;

	// Working word of the conversion: BCD digits above, binary bits still to shift in below.
	typedef logic [BcdWidth+ValueWidth-1:0] dabble_t;
	typedef logic [BcdDigits-1:0] blank_mask_t;

	// One double-dabble step: correct every BCD digit of five or more, then shift left.
	function automatic dabble_t dabble_step(input dabble_t word);
		dabble_t w;
		w = word;
		for (int d = 0; d < BcdDigits; d++) begin
			if (w[ValueWidth+4*d +: 4] >= 4'd5) begin
				w[ValueWidth+4*d +: 4] = w[ValueWidth+4*d +: 4] + 4'd3;
			end
		end
		return w << 1;
	endfunction

	// A position from the fourth up is blank when it and every digit above it are zero.
	function automatic blank_mask_t blank_mask(input logic [BcdWidth-1:0] bcd);
		blank_mask_t mask;
		logic nonzero;
		mask = '0;
		nonzero = 1'b0;
		for (int d = BcdDigits - 1; d >= 0; d--) begin
			nonzero = nonzero | (bcd[4*d +: 4] != 4'd0);
			if (d >= AlwaysShown) begin
				mask[d] = !nonzero;
			end
		end
		return mask;
	endfunction

endpackage

[sv/decimal_digit_display_writer_top.sv]
// Top level of the digit display writer: binary to BCD pipeline and digit write serializer.
// The first digit write leaves on strobe after stages s1 to s5, the serializer and the output register.
// Throughput: eight writes per value, one per cycle; once the stages are full, a value is taken
// only as the serializer, which sends the eight writes of one value in turn, ends a run.
// Up to five more values wait in the five conversion stages meanwhile.
// Reset clears all valid bits and the strobe; the receiver cannot stall the writes.
module decimal_digit_display_writer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ddw_pkg::ValueWidth-1:0]  value,
	output logic                            strobe,
	output logic [ddw_pkg::AddrWidth-1:0]   digit_address,
	output logic [ddw_pkg::CodeWidth-1:0]   digit_code,
	output logic                            last_write
);

	`include "assert_macros.svh"

	// Conversion pipeline registers.
	ddw_pkg::dabble_t word_s1, word_s2, word_s3, word_s4, word_s5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	ddw_pkg::dabble_t next_s2, next_s3, next_s4, next_s5;
	logic take_s1, take_s2, take_s3, take_s4, take_s5;

	// Serializer registers.
	logic [4*ddw_pkg::DigitCount-1:0] digits_q;
	logic [ddw_pkg::DigitCount-1:0]   blank_q;
	logic [ddw_pkg::CountWidth-1:0]   count_q;
	logic                             active_q;
	logic                             ser_free;
	logic                             ser_load;
	ddw_pkg::blank_mask_t             load_mask;
	logic [ddw_pkg::CodeWidth-1:0]    code_now;

	// A stage takes new data when it is empty or its content moves on in the same cycle.
	assign ser_free = !active_q || (count_q == ddw_pkg::CountWidth'(ddw_pkg::DigitCount - 1));
	assign take_s5 = !valid_s5 || ser_free;
	assign take_s4 = !valid_s4 || take_s5;
	assign take_s3 = !valid_s3 || take_s4;
	assign take_s2 = !valid_s2 || take_s3;
	assign take_s1 = !valid_s1 || take_s2;
	assign busy = !take_s1;
	assign ser_load = valid_s5 && ser_free;

	// Double-dabble steps between the stages.
	always_comb begin
		next_s2 = word_s1;
		for (int i = 0; i < ddw_pkg::StageSteps; i++) begin
			next_s2 = ddw_pkg::dabble_step(next_s2);
		end
	end

	always_comb begin
		next_s3 = word_s2;
		for (int i = 0; i < ddw_pkg::StageSteps; i++) begin
			next_s3 = ddw_pkg::dabble_step(next_s3);
		end
	end

	always_comb begin
		next_s4 = word_s3;
		for (int i = 0; i < ddw_pkg::StageSteps; i++) begin
			next_s4 = ddw_pkg::dabble_step(next_s4);
		end
	end

	always_comb begin
		next_s5 = word_s4;
		for (int i = 0; i < ddw_pkg::LastSteps; i++) begin
			next_s5 = ddw_pkg::dabble_step(next_s5);
		end
	end

	// Valid bits of the conversion pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (take_s1) valid_s1 <= start;
			if (take_s2) valid_s2 <= valid_s1;
			if (take_s3) valid_s3 <= valid_s2;
			if (take_s4) valid_s4 <= valid_s3;
			if (take_s5) valid_s5 <= valid_s4;
		end
	end

	// Data of the conversion pipeline.
	always_ff @(posedge clk) begin
		if (take_s1) word_s1 <= {{ddw_pkg::BcdWidth{1'b0}}, value};
		if (take_s2) word_s2 <= next_s2;
		if (take_s3) word_s3 <= next_s3;
		if (take_s4) word_s4 <= next_s4;
		if (take_s5) word_s5 <= next_s5;
	end

	assign load_mask = ddw_pkg::blank_mask(word_s5[ddw_pkg::ValueWidth +: ddw_pkg::BcdWidth]);

	// Serializer control: counts the writes of the value in hand.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= '0;
		end else if (ser_load) begin
			active_q <= 1'b1;
			count_q  <= '0;
		end else if (active_q) begin
			if (count_q == ddw_pkg::CountWidth'(ddw_pkg::DigitCount - 1)) begin
				active_q <= 1'b0;
			end
			count_q <= count_q + 1'b1;
		end
	end

	// Serializer data: the lowest digit and blank flag are always the next to send.
	always_ff @(posedge clk) begin
		if (ser_load) begin
			digits_q <= word_s5[ddw_pkg::ValueWidth +: 4*ddw_pkg::DigitCount];
			blank_q  <= load_mask[ddw_pkg::DigitCount-1:0];
		end else if (active_q) begin
			digits_q <= digits_q >> 4;
			blank_q  <= blank_q >> 1;
		end
	end

	// Code of the current position, with the decimal point on its fixed position.
	always_comb begin
		if (blank_q[0]) begin
			code_now = ddw_pkg::BlankCode;
		end else begin
			code_now = {{(ddw_pkg::CodeWidth-4){1'b0}}, digits_q[3:0]};
		end
		if ((ddw_pkg::AddrWidth'(count_q) + 1'b1) == ddw_pkg::PointPosition) begin
			code_now = code_now | ddw_pkg::PointBit;
		end
	end

	// Output register: one digit write transfer per cycle while a value is in hand.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		digit_address <= ddw_pkg::AddrWidth'(count_q) + 1'b1;
		digit_code    <= code_now;
		last_write    <= (count_q == ddw_pkg::CountWidth'(ddw_pkg::DigitCount - 1));
	end

	// The writes of one value come in consecutive cycles with rising positions.
	`ASSERT_NEXT(a_run_contiguous, strobe && !last_write, strobe && (digit_address == $past(digit_address) + 1'b1), "digit write run broken")
	// The final write of a run is on the top position.
	`ASSERT_ALWAYS(a_last_position, !strobe || !last_write || (digit_address == ddw_pkg::AddrWidth'(ddw_pkg::DigitCount)), "last write not on top position")
	// The always-shown positions carry a decimal digit, never the blank code.
	`ASSERT_ALWAYS(a_low_not_blank, !strobe || (digit_address > 4'd3) || (digit_code[3:0] <= 4'd9), "low position blanked")
	// A new value enters the serializer only when the previous run is ending.
	`ASSERT_ALWAYS(a_load_free, !ser_load || !active_q || (count_q == ddw_pkg::CountWidth'(ddw_pkg::DigitCount - 1)), "serializer reloaded mid run")

endmodule
